>>> rtl/dpp_pkg.sv
// Shared types and constants for the depth-pixel-to-point block.
// No dependencies; every other file imports this package.
`default_nettype none

package dpp_pkg;

	// Counters and frame geometry
	localparam int MAX_DIM = 1024;
	localparam int CNT_W   = $clog2(MAX_DIM);
	localparam int DIM_W   = 11;

	// Field widths
	localparam int CTR_W   = 14;
	localparam int FOC_W   = 16;
	localparam int DEPTH_W = 16;
	localparam int COLOR_W = 8;
	localparam int COORD_W = 28;

	// Offset, product and dividend widths
	localparam int POS_W   = CNT_W + 4;
	localparam int OFS_W   = (POS_W > CTR_W) ? POS_W : CTR_W;
	localparam int PROD_W  = OFS_W + DEPTH_W;
	localparam int FRAC_SH = 8;
	localparam int NUM_W   = ((PROD_W + FRAC_SH + 2) / 2) * 2;
	localparam int ITERS   = NUM_W / 2;
	localparam int ITER_W  = $clog2(ITERS + 1);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_COL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_ROW    = 3'd5;

	typedef struct packed {
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
		logic [CTR_W-1:0] center_col_q4;
		logic [CTR_W-1:0] center_row_q4;
		logic [FOC_W-1:0] focal_col_q4;
		logic [FOC_W-1:0] focal_row_q4;
	} cfg_t;

	// One classified pixel waiting for the back end
	typedef struct packed {
		logic [OFS_W-1:0]   col_mag;
		logic               col_neg;
		logic [OFS_W-1:0]   row_mag;
		logic               row_neg;
		logic [DEPTH_W-1:0] depth;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               frame_end;
	} item_t;

	// Queue handshake seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

>>> rtl/depth_pixel_to_point_top.sv
// Pinhole back-projection of a raster depth and color stream: each accepted
// pixel yields one point, in order. The front end accepts a pixel while the
// queue is not full and places it in a two-entry queue; the back end pops a
// pixel, multiplies offset by depth, loads the dividers, then runs the
// restoring divider, which produces two quotient bits a cycle over a 40-bit
// dividend. The back end pops no new pixel until the previous point has entered
// the output register; up to four pixels may be inside the block: two in the
// queue, one in the back end and one finished point in the output register.
// Configuration is taken at any time on its own channel but is to be
// written only while the block is empty. Zero depth gives point_valid low with
// zero coordinates; x and y are in 1/256 mm, rounded and saturated to 28 bits.
// Depends on dpp_pkg, dpp_front, dpp_queue, dpp_back.
`default_nettype none

module depth_pixel_to_point_top
	import dpp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [DEPTH_W-1:0]     depth_mm,
	input  wire logic [COLOR_W-1:0]     red,
	input  wire logic [COLOR_W-1:0]     green,
	input  wire logic [COLOR_W-1:0]     blue,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [COORD_W-1:0]   point_x,
	output logic signed [COORD_W-1:0]   point_y,
	output logic [DEPTH_W-1:0]          point_z,
	output logic                        point_valid,
	output logic [COLOR_W-1:0]          out_red,
	output logic [COLOR_W-1:0]          out_green,
	output logic [COLOR_W-1:0]          out_blue,
	output logic                        frame_end,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t          cfg_q;
	queue_status_t q_status;
	item_t         push_item;
	item_t         pop_item;
	logic          push;
	logic          pop;

	assign cfg_ready = 1'b1;

	// Register file; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= DIM_W'(640);
			cfg_q.frame_height  <= DIM_W'(480);
			cfg_q.center_col_q4 <= CTR_W'(5120);
			cfg_q.center_row_q4 <= CTR_W'(3840);
			cfg_q.focal_col_q4  <= FOC_W'(8400);
			cfg_q.focal_row_q4  <= FOC_W'(8400);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width   <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height  <= cfg_data[DIM_W-1:0];
				REG_CENTER_COL:   cfg_q.center_col_q4 <= cfg_data[CTR_W-1:0];
				REG_CENTER_ROW:   cfg_q.center_row_q4 <= cfg_data[CTR_W-1:0];
				REG_FOCAL_COL:    cfg_q.focal_col_q4  <= cfg_data[FOC_W-1:0];
				REG_FOCAL_ROW:    cfg_q.focal_row_q4  <= cfg_data[FOC_W-1:0];
				default: ;
			endcase
		end
	end

	dpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.depth_mm  (depth_mm),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cfg       (cfg_q),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	dpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	dpp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_status    (q_status),
		.q_item      (pop_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.point_valid (point_valid),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.frame_end   (frame_end)
	);

endmodule

`default_nettype wire

>>> rtl/dpp_queue.sv
// Short register queue between the front end and the back end.
// Depends on dpp_pkg for the item type and the depth.
`default_nettype none

module dpp_queue
	import dpp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire item_t         push_item,
	input  wire logic          pop,
	output item_t              pop_item,
	output queue_status_t      status
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			r = '0;
		else
			r = p + 1'b1;
		return r;
	endfunction

	assign status.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign pop_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/dpp_front.sv
// Front end: accepts pixels, tracks raster position and computes the
// signed offsets from the principal point. Depends on dpp_pkg.
`default_nettype none

module dpp_front
	import dpp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [DEPTH_W-1:0] depth_mm,
	input  wire logic [COLOR_W-1:0] red,
	input  wire logic [COLOR_W-1:0] green,
	input  wire logic [COLOR_W-1:0] blue,
	input  wire cfg_t               cfg,
	input  wire queue_status_t      q_status,
	output logic                    push,
	output item_t                   push_item
);

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] last_col;
	logic [CNT_W-1:0] last_row;
	logic             col_wrap;
	logic             row_wrap;
	logic [OFS_W-1:0] col_pos;
	logic [OFS_W-1:0] row_pos;
	logic [OFS_W-1:0] col_ctr;
	logic [OFS_W-1:0] row_ctr;

	// Last valid counter value for a frame size; zero acts as one, oversize as MAX_DIM
	function automatic logic [CNT_W-1:0] last_index(input logic [DIM_W-1:0] size);
		logic [CNT_W-1:0] r;
		if (size == '0)
			r = '0;
		else if (32'(size) > 32'(MAX_DIM))
			r = CNT_W'(MAX_DIM - 1);
		else
			r = CNT_W'(size - 1'b1);
		return r;
	endfunction

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	assign last_col = last_index(cfg.frame_width);
	assign last_row = last_index(cfg.frame_height);
	assign col_wrap = (col_q >= last_col);
	assign row_wrap = (row_q >= last_row);

	assign col_pos = OFS_W'({col_q, 4'b0000});
	assign row_pos = OFS_W'({row_q, 4'b0000});
	assign col_ctr = OFS_W'(cfg.center_col_q4);
	assign row_ctr = OFS_W'(cfg.center_row_q4);

	always_comb begin
		push_item.col_neg   = (col_pos < col_ctr);
		push_item.col_mag   = push_item.col_neg ? (col_ctr - col_pos) : (col_pos - col_ctr);
		push_item.row_neg   = (row_pos < row_ctr);
		push_item.row_mag   = push_item.row_neg ? (row_ctr - row_pos) : (row_pos - row_ctr);
		push_item.depth     = depth_mm;
		push_item.red       = red;
		push_item.green     = green;
		push_item.blue      = blue;
		push_item.frame_end = col_wrap && row_wrap;
	end

	// Advance the raster position on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/dpp_div.sv
// Restoring divider, two quotient bits per cycle, unsigned.
// Depends on dpp_pkg for the dividend and divisor widths.
`default_nettype none

module dpp_div
	import dpp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [FOC_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);

	logic [NUM_W-1:0]  num_q;
	logic [FOC_W-1:0]  rem_q;
	logic [ITER_W-1:0] cnt_q;
	logic [FOC_W:0]    t1;
	logic [FOC_W:0]    r1;
	logic [FOC_W:0]    t2;
	logic [FOC_W:0]    r2;
	logic              ge1;
	logic              ge2;

	always_comb begin
		t1  = {rem_q, num_q[NUM_W-1]};
		ge1 = (t1 >= {1'b0, den});
		r1  = ge1 ? (t1 - {1'b0, den}) : t1;
		t2  = {r1[FOC_W-1:0], num_q[NUM_W-2]};
		ge2 = (t2 >= {1'b0, den});
		r2  = ge2 ? (t2 - {1'b0, den}) : t2;
	end

	assign done = (cnt_q == '0);
	assign quo  = num_q;

	// Dividend bits shift out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (!done) begin
			num_q <= {num_q[NUM_W-3:0], ge1, ge2};
			rem_q <= r2[FOC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (start)
			cnt_q <= ITER_W'(ITERS);
		else if (!done)
			cnt_q <= cnt_q - 1'b1;
	end

endmodule

`default_nettype wire

>>> rtl/dpp_back.sv
// Back end: multiplies offset by depth, divides by focal length with
// rounding, saturates and holds the result. Depends on dpp_pkg, dpp_div.
`default_nettype none

module dpp_back
	import dpp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire queue_status_t      q_status,
	input  wire item_t              q_item,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [COORD_W-1:0] point_x,
	output logic signed [COORD_W-1:0] point_y,
	output logic [DEPTH_W-1:0]      point_z,
	output logic                    point_valid,
	output logic [COLOR_W-1:0]      out_red,
	output logic [COLOR_W-1:0]      out_green,
	output logic [COLOR_W-1:0]      out_blue,
	output logic                    frame_end
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MUL   = 5'b00010,
		S_START = 5'b00100,
		S_DIV   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	item_t             item_q;
	logic [PROD_W-1:0] prod_x_q;
	logic [PROD_W-1:0] prod_y_q;
	logic [FOC_W-1:0]  den_x;
	logic [FOC_W-1:0]  den_y;
	logic [NUM_W-1:0]  num_x;
	logic [NUM_W-1:0]  num_y;
	logic [NUM_W-1:0]  quo_x;
	logic [NUM_W-1:0]  quo_y;
	logic              done_x;
	logic              done_y;
	logic              div_start;
	logic              out_free;
	logic              load_out;
	logic              out_valid_q;

	// Clamp magnitude to the coordinate range and apply the sign
	function automatic logic [COORD_W-1:0] sat_coord(input logic [NUM_W-1:0] q,
			input logic neg);
		logic              big;
		logic [COORD_W-1:0] r;
		big = |q[NUM_W-1:COORD_W-1];
		if (neg)
			r = big ? {1'b1, {(COORD_W-1){1'b0}}} : (~q[COORD_W-1:0] + 1'b1);
		else
			r = big ? {1'b0, {(COORD_W-1){1'b1}}} : q[COORD_W-1:0];
		return r;
	endfunction

	// A zero focal length divides as one
	assign den_x = (cfg.focal_col_q4 == '0) ? FOC_W'(1) : cfg.focal_col_q4;
	assign den_y = (cfg.focal_row_q4 == '0) ? FOC_W'(1) : cfg.focal_row_q4;

	// Half the divisor added up front rounds the magnitude to nearest
	assign num_x = NUM_W'({prod_x_q, {FRAC_SH{1'b0}}}) + NUM_W'(den_x >> 1);
	assign num_y = NUM_W'({prod_y_q, {FRAC_SH{1'b0}}}) + NUM_W'(den_y >> 1);

	assign div_start = (state_q == S_START);
	assign pop       = (state_q == S_IDLE) && !q_status.empty;
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = out_free && done_x && done_y &&
		((state_q == S_DIV) || (state_q == S_DONE));
	assign out_valid = out_valid_q;

	dpp_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_x),
		.den    (den_x),
		.done   (done_x),
		.quo    (quo_x)
	);

	dpp_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_y),
		.den    (den_y),
		.done   (done_y),
		.quo    (quo_y)
	);

	always_ff @(posedge clk) begin
		if (pop)
			item_q <= q_item;
		if (state_q == S_MUL) begin
			prod_x_q <= PROD_W'(item_q.col_mag) * PROD_W'(item_q.depth);
			prod_y_q <= PROD_W'(item_q.row_mag) * PROD_W'(item_q.depth);
		end
		if (load_out) begin
			point_x     <= sat_coord(quo_x, item_q.col_neg);
			point_y     <= sat_coord(quo_y, item_q.row_neg);
			point_z     <= item_q.depth;
			point_valid <= (item_q.depth != '0);
			out_red     <= item_q.red;
			out_green   <= item_q.green;
			out_blue    <= item_q.blue;
			frame_end   <= item_q.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE:  if (pop) state_q <= S_MUL;
				S_MUL:   state_q <= S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (done_x && done_y)
						state_q <= out_free ? S_IDLE : S_DONE;
				end
				S_DONE:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/dpp_checker.sv
// Port-level checks on the point output, bound to the top level.
// Depends on dpp_pkg for field widths.
`default_nettype none

module dpp_checker
	import dpp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic [COORD_W-1:0]   point_x,
	input  wire logic [COORD_W-1:0]   point_y,
	input  wire logic [DEPTH_W-1:0]   point_z,
	input  wire logic                 point_valid
);

	// Hold a stalled point
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("point dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(point_x) && $stable(point_y))
		else $error("point coordinates changed while stalled");

	// A bad point carries zero coordinates
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> point_x == '0 && point_y == '0 && point_z == '0)
		else $error("bad point with nonzero coordinates");

	// A good point has a nonzero range
	a_good_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_valid |-> point_z != '0)
		else $error("good point with zero range");

endmodule

bind depth_pixel_to_point_top dpp_checker u_dpp_checker (.*);

`default_nettype wire

>>> tb/sv/depth_pixel_to_point_top_test.sv
// Self-checking bench for depth_pixel_to_point_top: streams depth and color pixels,
// predicts each back-projected point in fixed point and compares field by field.
// Depends on dpp_pkg and the depth_pixel_to_point_top RTL.
`default_nettype none

module depth_pixel_to_point_top_test;
	import dpp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int ITEMS_PER_SET = 150;
	localparam int HOLD_CYCLES   = 600;
	localparam int STALL_LIMIT   = 5000;
	localparam int TAIL_CYCLES   = 60;
	localparam int MAX_SHOWN     = 40;

	localparam longint unsigned COORD_POS_LIM = 134217727;
	localparam longint unsigned COORD_NEG_LIM = 134217728;

	// Indexes past the register file; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_LIST [6] = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT,
		REG_CENTER_COL, REG_CENTER_ROW, REG_FOCAL_COL, REG_FOCAL_ROW};

	typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_e;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [DEPTH_W-1:0]        z;
		logic                      valid;
		logic [COLOR_W-1:0]        red;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        blue;
		logic                      frame_end;
	} point_t;

	typedef struct packed {
		step_kind_e                kind;
		logic [CFG_IDX_W-1:0]      reg_index;
		logic [CFG_DATA_W-1:0]     reg_data;
		logic [DEPTH_W-1:0]        depth;
		logic [COLOR_W-1:0]        red;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        blue;
		logic                      typed;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      valid;
		logic                      frame_end;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [DEPTH_W-1:0]    depth_mm = '0;
	logic [COLOR_W-1:0]    red = '0;
	logic [COLOR_W-1:0]    green = '0;
	logic [COLOR_W-1:0]    blue = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [DEPTH_W-1:0]    point_z;
	logic                  point_valid;
	logic [COLOR_W-1:0]    out_red;
	logic [COLOR_W-1:0]    out_green;
	logic [COLOR_W-1:0]    out_blue;
	logic                  frame_end;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state: camera setup and raster position
	cfg_t        cam_setup;
	int unsigned pix_col;
	int unsigned pix_row;

	point_t pending_points[$];
	int     err_count = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	int     hold_req = 0;
	int     hold_ack = 0;
	int     hold_left = 0;
	int     stall_cycles = 0;

	// After reset: first pixels checked by hand against the default camera
	step_t directed_steps [24] = '{
		'{kind: STEP_PIXEL, depth: 16'd8400, typed: 1'b1, x: -28'sd1310720,
			y: -28'sd983040, valid: 1'b1, default: '0},
		'{kind: STEP_PIXEL, depth: 16'd0, red: 8'hff, green: 8'hff, blue: 8'hff,
			typed: 1'b1, default: '0},
		'{kind: STEP_PIXEL, depth: 16'hffff, red: 8'haa, green: 8'h55, blue: 8'h0f,
			default: '0},
		'{kind: STEP_PIXEL, depth: 16'd1, red: 8'h55, green: 8'haa, blue: 8'hf0,
			default: '0},
		// zero focal length, extreme principal points
		'{kind: STEP_WRITE, reg_index: REG_FOCAL_COL, reg_data: 16'd0, default: '0},
		'{kind: STEP_WRITE, reg_index: REG_FOCAL_ROW, reg_data: 16'hffff, default: '0},
		'{kind: STEP_WRITE, reg_index: REG_CENTER_COL, reg_data: 16'd16383, default: '0},
		'{kind: STEP_WRITE, reg_index: REG_CENTER_ROW, reg_data: 16'd0, default: '0},
		'{kind: STEP_PIXEL, depth: 16'hffff, red: 8'h01, green: 8'h02, blue: 8'h04,
			typed: 1'b1, x: -28'sd134217728, y: 28'sd0, valid: 1'b1, default: '0},
		'{kind: STEP_PIXEL, depth: 16'd1, red: 8'h80, green: 8'h40, blue: 8'h20,
			default: '0},
		// zero frame size; the column counter already sits beyond it
		'{kind: STEP_WRITE, reg_index: REG_FRAME_WIDTH, reg_data: 16'd0, default: '0},
		'{kind: STEP_WRITE, reg_index: REG_FRAME_HEIGHT, reg_data: 16'd0, default: '0},
		'{kind: STEP_PIXEL, depth: 16'd0, red: 8'h12, green: 8'h34, blue: 8'h56,
			typed: 1'b1, frame_end: 1'b1, default: '0},
		'{kind: STEP_PIXEL, depth: 16'd300, red: 8'hfe, green: 8'hdc, blue: 8'hba,
			default: '0},
		// oversized height, dropped upper bits, writes past the register file
		'{kind: STEP_WRITE, reg_index: REG_FRAME_WIDTH, reg_data: 16'd2, default: '0},
		'{kind: STEP_WRITE, reg_index: REG_FRAME_HEIGHT, reg_data: 16'hffff, default: '0},
		'{kind: STEP_WRITE, reg_index: REG_UNUSED_LO, reg_data: 16'hffff, default: '0},
		'{kind: STEP_WRITE, reg_index: REG_UNUSED_HI, reg_data: 16'h5555, default: '0},
		'{kind: STEP_WRITE, reg_index: REG_FOCAL_ROW, reg_data: 16'd0, default: '0},
		'{kind: STEP_PIXEL, depth: 16'h8000, red: 8'h11, green: 8'h22, blue: 8'h33,
			default: '0},
		'{kind: STEP_PIXEL, depth: 16'hffff, red: 8'h44, green: 8'h55, blue: 8'h66,
			default: '0},
		'{kind: STEP_PIXEL, depth: 16'h8000, red: 8'h77, green: 8'h88, blue: 8'h99,
			typed: 1'b1, x: -28'sd134217728, y: 28'sd134217727, valid: 1'b1,
			default: '0},
		'{kind: STEP_PIXEL, depth: 16'd1, red: 8'haa, green: 8'hbb, blue: 8'hcc,
			default: '0},
		'{kind: STEP_PIXEL, depth: 16'hffff, red: 8'hff, green: 8'h00, blue: 8'hff,
			default: '0}
	};

	depth_pixel_to_point_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.depth_mm    (depth_mm),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.point_valid (point_valid),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.frame_end   (frame_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	task automatic report_error(input string msg);
		err_count++;
		if (err_count <= MAX_SHOWN)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	// Offset from the principal point times depth over focal length, in 1/256 mm,
	// rounded half away from zero on the magnitude, then saturated
	function automatic logic signed [COORD_W-1:0] back_project(input int unsigned count,
			input int unsigned center, input int unsigned focal, input int unsigned depth);
		longint unsigned pos;
		longint unsigned mag;
		longint unsigned den;
		longint unsigned quot;
		bit neg;
		pos = count;
		pos = pos * 16;
		neg = pos < center;
		mag = neg ? center - pos : pos - center;
		den = (focal == 0) ? 1 : focal;
		quot = (mag * depth * 256 + den / 2) / den;
		if (neg) begin
			if (quot > COORD_NEG_LIM)
				quot = COORD_NEG_LIM;
			quot = 0 - quot;
		end else if (quot > COORD_POS_LIM) begin
			quot = COORD_POS_LIM;
		end
		return quot[COORD_W-1:0];
	endfunction

	function automatic point_t predict_point(input logic [DEPTH_W-1:0] d,
			input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] b);
		point_t p;
		bit col_wrap;
		bit row_wrap;
		col_wrap = pix_col >= clamp_dim(cam_setup.frame_width) - 1;
		row_wrap = pix_row >= clamp_dim(cam_setup.frame_height) - 1;
		p = '0;
		if (d != 0) begin
			p.x = back_project(pix_col, cam_setup.center_col_q4, cam_setup.focal_col_q4, d);
			p.y = back_project(pix_row, cam_setup.center_row_q4, cam_setup.focal_row_q4, d);
			p.z = d;
			p.valid = 1'b1;
		end
		p.red = r;
		p.green = g;
		p.blue = b;
		p.frame_end = col_wrap && row_wrap;
		// advance the raster position
		if (col_wrap) begin
			pix_col = 0;
			pix_row = row_wrap ? 0 : pix_row + 1;
		end else begin
			pix_col = pix_col + 1;
		end
		return p;
	endfunction

	function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_FRAME_WIDTH:  cam_setup.frame_width = data[DIM_W-1:0];
			REG_FRAME_HEIGHT: cam_setup.frame_height = data[DIM_W-1:0];
			REG_CENTER_COL:   cam_setup.center_col_q4 = data[CTR_W-1:0];
			REG_CENTER_ROW:   cam_setup.center_row_q4 = data[CTR_W-1:0];
			REG_FOCAL_COL:    cam_setup.focal_col_q4 = data[FOC_W-1:0];
			REG_FOCAL_ROW:    cam_setup.focal_row_q4 = data[FOC_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
		case (idx)
			REG_FRAME_WIDTH, REG_FRAME_HEIGHT:
				case ($urandom_range(5))
					0: return CFG_DATA_W'(1);
					1, 2: return CFG_DATA_W'($urandom_range(2, 12));
					3: return CFG_DATA_W'($urandom_range(13, 64));
					4: return CFG_DATA_W'(MAX_DIM);
					default: return CFG_DATA_W'($urandom_range(0, 16'hffff));
				endcase
			REG_CENTER_COL, REG_CENTER_ROW:
				case ($urandom_range(3))
					0: return '0;
					1: return CFG_DATA_W'(16383);
					default: return CFG_DATA_W'($urandom_range(0, 16383));
				endcase
			default:
				case ($urandom_range(5))
					0: return CFG_DATA_W'(1600);
					1: return 16'hffff;
					2: return '0;
					default: return CFG_DATA_W'($urandom_range(1600, 16'hffff));
				endcase
		endcase
	endfunction

	function automatic logic [DEPTH_W-1:0] pick_depth();
		case ($urandom_range(7))
			0: return '0;
			1: return 16'hffff;
			2: return DEPTH_W'($urandom_range(1, 255));
			default: return DEPTH_W'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	// Offer one pixel, idling first at random; valid stays up across back-to-back items
	task automatic send_pixel(input logic [DEPTH_W-1:0] d, input logic [COLOR_W-1:0] r,
			input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b,
			input bit typed, input point_t typed_point);
		point_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		depth_mm <= d;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (!in_ready);
		p = predict_point(d, r, g, b);
		pending_points.push_back(typed ? typed_point : p);
	endtask

	// Drop valid and hold until every pending point has come out
	task automatic wait_until_empty();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_write(idx, data);
	endtask

	task automatic load_random_setup();
		wait_until_empty();
		foreach (REG_LIST[k])
			write_reg(REG_LIST[k], pick_reg_value(REG_LIST[k]));
		if ($urandom_range(2) == 0)
			write_reg($urandom_range(1) ? REG_UNUSED_HI : REG_UNUSED_LO,
				CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic compare_field(input string name, input logic signed [31:0] got,
			input logic signed [31:0] want);
		if (got !== want)
			report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
	endtask

	// Receiver: random back-pressure, plus a long hold when one is requested
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				report_error("point delivered with no pixel pending");
			end else begin
				want = pending_points.pop_front();
				compare_field("point_x", point_x, want.x);
				compare_field("point_y", point_y, want.y);
				compare_field("point_z", point_z, want.z);
				compare_field("point_valid", point_valid, want.valid);
				compare_field("out_red", out_red, want.red);
				compare_field("out_green", out_green, want.green);
				compare_field("out_blue", out_blue, want.blue);
				compare_field("frame_end", frame_end, want.frame_end);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int send_idle_by_mode [3];
		int recv_idle_by_mode [3];
		bit cfg_open;
		point_t typed_point;
		step_t st;
		send_idle_by_mode = '{37, 88, 0};
		recv_idle_by_mode = '{88, 37, 0};
		cfg_open = 0;
		cam_setup.frame_width = 640;
		cam_setup.frame_height = 480;
		cam_setup.center_col_q4 = 5120;
		cam_setup.center_row_q4 = 3840;
		cam_setup.focal_col_q4 = 8400;
		cam_setup.focal_row_q4 = 8400;
		pix_col = 0;
		pix_row = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 20;
		recv_idle_pct = 20;
		foreach (directed_steps[i]) begin
			st = directed_steps[i];
			if (st.kind == STEP_WRITE) begin
				if (!cfg_open)
					wait_until_empty();
				write_reg(st.reg_index, st.reg_data);
				cfg_open = 1;
			end else begin
				if (cfg_open)
					cfg_valid <= 1'b0;
				cfg_open = 0;
				typed_point.x = st.x;
				typed_point.y = st.y;
				typed_point.z = st.valid ? st.depth : '0;
				typed_point.valid = st.valid;
				typed_point.red = st.red;
				typed_point.green = st.green;
				typed_point.blue = st.blue;
				typed_point.frame_end = st.frame_end;
				send_pixel(st.depth, st.red, st.green, st.blue, st.typed, typed_point);
			end
		end

		for (int mode = 0; mode < 3; mode++) begin
			for (int set = 0; set < 3; set++) begin
				load_random_setup();
				send_idle_pct = send_idle_by_mode[mode];
				recv_idle_pct = recv_idle_by_mode[mode];
				// stall the output long enough for the block to fill and push back
				if (mode == 2 && set == 0)
					hold_req++;
				repeat (ITEMS_PER_SET)
					send_pixel(pick_depth(), COLOR_W'($urandom), COLOR_W'($urandom),
						COLOR_W'($urandom), 1'b0, '0);
			end
		end

		wait_until_empty();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

>>> depth_pixel_to_point_top.f
rtl/dpp_pkg.sv
rtl/dpp_queue.sv
rtl/dpp_front.sv
rtl/dpp_div.sv
rtl/dpp_back.sv
rtl/depth_pixel_to_point_top.sv
rtl/dpp_checker.sv
tb/sv/depth_pixel_to_point_top_test.sv
